// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDIV_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sidiv assertion failed");

// The condition must never be true outside reset.
`define SIDIV_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sidiv assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define SIDIV_ASSERT_DELAY(label, pre, n, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
        else $error("sidiv assertion failed");

`endif

// ===== rtl/core/sidiv_pkg.sv =====
package sidiv_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned DT_W    = 3;
    // One quotient bit is produced by each cell of the chain.
    localparam int unsigned N_CELLS = DATA_W;
    // Registers between an accepted request and its result strobe: the input
    // stage, every cell and the output stage hold one each.
    localparam int unsigned LATENCY = N_CELLS + 2;

    localparam logic [DT_W-1:0] DT_INT32 = 3'd4;

    // Operand size, taken from data_type[2:1].
    typedef enum logic [1:0] {
        SZ_8  = 2'd0,
        SZ_16 = 2'd1,
        SZ_32 = 2'd2,
        SZ_64 = 2'd3
    } size_t;

    // Per-request control that rides along with the division.
    typedef struct packed {
        logic last;
        logic zero_div;
        logic ovf;
        logic dvd_pos;
        logic neg;
    } item_ctl_t;

    // Payload handed from one cell to the next.
    typedef struct packed {
        item_ctl_t         ctl;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dvs;
    } stage_t;

    function automatic logic is_signed_type(input logic [DT_W-1:0] dt);
        return ~dt[0];
    endfunction

    function automatic logic [DATA_W-1:0] type_mask(input logic [DT_W-1:0] dt);
        logic [DATA_W-1:0] m;
        unique case (size_t'(dt[2:1]))
            SZ_8:  m = 64'h0000_0000_0000_00FF;
            SZ_16: m = 64'h0000_0000_0000_FFFF;
            SZ_32: m = 64'h0000_0000_FFFF_FFFF;
            SZ_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Sign extend from the type width.
    function automatic logic [DATA_W-1:0] sext_type(input logic [DATA_W-1:0] v,
                                                    input logic [DT_W-1:0]   dt);
        logic [DATA_W-1:0] r;
        unique case (size_t'(dt[2:1]))
            SZ_8:  r = {{56{v[7]}}, v[7:0]};
            SZ_16: r = {{48{v[15]}}, v[15:0]};
            SZ_32: r = {{32{v[31]}}, v[31:0]};
            SZ_64: r = v;
        endcase
        return r;
    endfunction

    // Sign or zero extend from the type width, as the type asks.
    function automatic logic [DATA_W-1:0] extend_type(input logic [DATA_W-1:0] v,
                                                      input logic [DT_W-1:0]   dt);
        return is_signed_type(dt) ? sext_type(v, dt) : (v & type_mask(dt));
    endfunction

    function automatic logic [DATA_W-1:0] type_max(input logic [DT_W-1:0] dt);
        return is_signed_type(dt) ? (type_mask(dt) >> 1) : type_mask(dt);
    endfunction

    function automatic logic [DATA_W-1:0] type_min(input logic [DT_W-1:0] dt);
        return is_signed_type(dt) ? ~(type_mask(dt) >> 1) : '0;
    endfunction

endpackage

// ===== rtl/core/saturating_integer_divider.sv =====
// Saturating integer divider. One request (dividend, divisor, last_in) is
// accepted on every clock cycle in which start is high; busy is always low,
// because the divider is a fully pipelined row of 64 identical cells, each of
// which resolves one quotient bit with one 65-bit subtract and compare and
// hands its partial remainder to the next cell on the following clock. The
// result of a request appears on quotient, zero_divisor, overflowed and
// last_out for exactly one cycle, marked by done, after it has been
// registered in the operand conditioning stage, in each of the 64 cells and
// in the output stage that restores the sign and applies saturation. Results
// come out in request order. The receiver cannot stall the divider, so it
// must take every result in the cycle that done is high. The data_type
// register (reset value: int32) is written through cfg_we and cfg_data and
// is read both at the input and at the output of the pipeline, so it must
// only be written while no request is in flight. A zero divisor saturates
// to the type maximum for a positive dividend and to the type minimum
// otherwise, and raises zero_divisor. The signed minimum divided by minus
// one saturates to the type maximum and raises overflowed.
module saturating_integer_divider
    import sidiv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DT_W-1:0]   cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    input  logic              last_in,
    output logic              done,
    output logic [DATA_W-1:0] quotient,
    output logic              zero_divisor,
    output logic              overflowed,
    output logic              last_out
);

    logic [DT_W-1:0] data_type_reg;

    // The chain has one link per cell plus the link from the input stage.
    logic   chain_valid [0:N_CELLS];
    stage_t chain_stage [0:N_CELLS];

    // The configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_type_reg <= DT_INT32;
        end
        else if (cfg_we)
        begin
            data_type_reg <= cfg_data;
        end
    end

    // Every stage advances on every clock, so a request is never refused.
    assign busy = 1'b0;

    // Masks the operands to the type width, takes magnitudes and flags the
    // saturating cases before the long division starts.
    sidiv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .dividend  (dividend),
        .divisor   (divisor),
        .last_in   (last_in),
        .data_type (data_type_reg),
        .out_valid (chain_valid[0]),
        .out_stage (chain_stage[0])
    );

    // The row of cells, most significant quotient bit first.
    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        sidiv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_stage  (chain_stage[i]),
            .out_valid (chain_valid[i+1]),
            .out_stage (chain_stage[i+1])
        );
    end

    // Restores the sign, applies saturation and extends to 64 bits.
    sidiv_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_valid[N_CELLS]),
        .in_stage     (chain_stage[N_CELLS]),
        .data_type    (data_type_reg),
        .done         (done),
        .quotient     (quotient),
        .zero_divisor (zero_divisor),
        .overflowed   (overflowed),
        .last_out     (last_out)
    );

endmodule

// ===== rtl/core/sidiv_prep.sv =====
module sidiv_prep
    import sidiv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [DATA_W-1:0]     dividend,
    input  logic [DATA_W-1:0]     divisor,
    input  logic                  last_in,
    input  logic [DT_W-1:0]       data_type,
    output logic                  out_valid,
    output stage_t                out_stage
);

    logic              valid_reg;
    stage_t            stage_reg;
    stage_t            stage_next;
    logic              sgn;
    logic [DATA_W-1:0] sa;
    logic [DATA_W-1:0] sb;
    logic              na;
    logic              nb;
    logic              zero;

    always_comb
    begin
        sgn  = is_signed_type(data_type);
        sa   = sgn ? sext_type(dividend, data_type) : (dividend & type_mask(data_type));
        sb   = sgn ? sext_type(divisor, data_type) : (divisor & type_mask(data_type));
        na   = sgn & sa[DATA_W-1];
        nb   = sgn & sb[DATA_W-1];
        zero = (sb == '0);

        stage_next.ctl.last     = last_in;
        stage_next.ctl.zero_div = zero;
        stage_next.ctl.ovf      = sgn && !zero && (sa == type_min(data_type)) && (&sb);
        stage_next.ctl.dvd_pos  = !na && (sa != '0);
        stage_next.ctl.neg      = na ^ nb;
        stage_next.rem          = '0;
        stage_next.quo          = na ? (~sa + 1'b1) : sa;
        stage_next.dvs          = nb ? (~sb + 1'b1) : sb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/core/sidiv_cell.sv =====
module sidiv_cell
    import sidiv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   out_valid,
    output stage_t out_stage
);

    logic          valid_reg;
    stage_t        stage_reg;
    stage_t        stage_next;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial = {in_stage.rem, in_stage.quo[DATA_W-1]};
        diff  = trial - {1'b0, in_stage.dvs};
        fits  = ~diff[DATA_W];

        stage_next.ctl = in_stage.ctl;
        stage_next.dvs = in_stage.dvs;
        stage_next.rem = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        stage_next.quo = {in_stage.quo[DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/core/sidiv_post.sv =====
module sidiv_post
    import sidiv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  stage_t            in_stage,
    input  logic [DT_W-1:0]   data_type,
    output logic              done,
    output logic [DATA_W-1:0] quotient,
    output logic              zero_divisor,
    output logic              overflowed,
    output logic              last_out
);

    logic              done_reg;
    logic [DATA_W-1:0] quotient_reg;
    logic [DATA_W-1:0] quotient_next;
    logic              zero_reg;
    logic              ovf_reg;
    logic              last_reg;
    logic [DATA_W-1:0] signed_q;

    always_comb
    begin
        signed_q = in_stage.ctl.neg ? (~in_stage.quo + 1'b1) : in_stage.quo;
        priority if (in_stage.ctl.zero_div)
        begin
            quotient_next = in_stage.ctl.dvd_pos ? type_max(data_type) : type_min(data_type);
        end
        else if (in_stage.ctl.ovf)
        begin
            quotient_next = type_max(data_type);
        end
        else
        begin
            quotient_next = extend_type(signed_q, data_type);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
        zero_reg     <= in_stage.ctl.zero_div;
        ovf_reg      <= in_stage.ctl.ovf;
        last_reg     <= in_stage.ctl.last;
    end

    assign done         = done_reg;
    assign quotient     = quotient_reg;
    assign zero_divisor = zero_reg;
    assign overflowed   = ovf_reg;
    assign last_out     = last_reg;

endmodule

// ===== rtl/core/sidiv_checker.sv =====
`include "assert_macros.svh"

module sidiv_checker
    import sidiv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              last_in,
    input logic              done,
    input logic [DATA_W-1:0] quotient,
    input logic              zero_divisor,
    input logic              overflowed,
    input logic              last_out
);

    // Every accepted request produces its result after the pipeline latency.
    `SIDIV_ASSERT_DELAY(a_req_to_done, start && !busy, LATENCY, done)

    // The last marker of a request comes out with its result.
    `SIDIV_ASSERT_DELAY(a_last_kept, start && !busy && last_in, LATENCY, last_out)

    // The two saturation causes exclude each other.
    `SIDIV_ASSERT_NEVER(a_flags_excl, done && zero_divisor && overflowed)

    // Overflow saturates to a positive maximum, never to a negative value.
    `SIDIV_ASSERT_IMPL(a_ovf_positive, done && overflowed, !quotient[DATA_W-1])

endmodule

bind saturating_integer_divider sidiv_checker u_sidiv_checker (.*);

// ===== tb/quotient_checker.sv =====
// Watches the request and result channels of the divider, predicts each
// quotient and compares the results in order.
module quotient_checker
    import sidiv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DT_W-1:0]   cfg_data,
    input  logic              start,
    input  logic              busy,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    input  logic              last_in,
    input  logic              done,
    input  logic [DATA_W-1:0] quotient,
    input  logic              zero_divisor,
    input  logic              overflowed,
    input  logic              last_out,
    output int                fail_count,
    output int                outstanding,
    output int                checked_count,
    output int                zero_div_count,
    output int                overflow_count
);

    typedef struct packed {
        logic [DATA_W-1:0] quo;
        logic              zdiv;
        logic              ovf;
        logic              last;
    } quo_result_t;

    logic [DT_W-1:0] active_type;
    quo_result_t     pending_quotients[$];
    int              errors;
    int              checked;
    int              zdiv_seen;
    int              ovf_seen;

    assign fail_count     = errors;
    assign outstanding    = pending_quotients.size();
    assign checked_count  = checked;
    assign zero_div_count = zdiv_seen;
    assign overflow_count = ovf_seen;

    // Sign extend the low w bits of v.
    function automatic logic [DATA_W-1:0] widen_signed(input logic [DATA_W-1:0] v,
                                                       input int unsigned       w);
        logic [DATA_W-1:0] keep;
        keep = (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
        v = v & keep;
        if (v[w-1])
            v = v | ~keep;
        return v;
    endfunction

    function automatic quo_result_t predict_quotient(input logic [DT_W-1:0]   dt,
                                                     input logic [DATA_W-1:0] a_raw,
                                                     input logic [DATA_W-1:0] b_raw,
                                                     input logic              last);
        int unsigned       w;
        logic [DATA_W-1:0] keep, a, b, sa, sb, tmax, tmin, ma, mb, mq, q;
        logic              na, nb;
        quo_result_t       r;
        case (size_t'(dt[2:1]))
            SZ_8:    w = 8;
            SZ_16:   w = 16;
            SZ_32:   w = 32;
            default: w = 64;
        endcase
        keep   = (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
        a      = a_raw & keep;
        b      = b_raw & keep;
        r.zdiv = 1'b0;
        r.ovf  = 1'b0;
        r.last = last;
        if (dt[0]) begin
            // Unsigned types: only the divide by zero needs care.
            if (b == '0) begin
                r.zdiv = 1'b1;
                q = (a != '0) ? keep : '0;
            end
            else begin
                q = a / b;
            end
        end
        else begin
            sa   = widen_signed(a, w);
            sb   = widen_signed(b, w);
            tmax = keep >> 1;
            tmin = widen_signed(tmax + 64'd1, w);
            na   = sa[DATA_W-1];
            nb   = sb[DATA_W-1];
            if (sb == '0) begin
                r.zdiv = 1'b1;
                q = (!na && sa != '0) ? tmax : tmin;
            end
            else if (sa == tmin && sb == '1) begin
                r.ovf = 1'b1;
                q = tmax;
            end
            else begin
                ma = na ? (64'd0 - sa) : sa;
                mb = nb ? (64'd0 - sb) : sb;
                mq = ma / mb;
                q  = (na != nb) ? (64'd0 - mq) : mq;
            end
            q = widen_signed(q & keep, w);
        end
        r.quo = q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quo_result_t got, want;
        if (!rst_n) begin
            active_type = DT_INT32;
            pending_quotients.delete();
            errors    = 0;
            checked   = 0;
            zdiv_seen = 0;
            ovf_seen  = 0;
        end
        else begin
            if (done) begin
                got = '{quo: quotient, zdiv: zero_divisor, ovf: overflowed, last: last_out};
                if (pending_quotients.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: quotient=%h zdiv=%b ovf=%b last=%b",
                                 got.quo, got.zdiv, got.ovf, got.last);
                end
                else begin
                    want = pending_quotients.pop_front();
                    checked++;
                    if (want.zdiv)
                        zdiv_seen++;
                    if (want.ovf)
                        ovf_seen++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: want q=%h z=%b o=%b l=%b, got q=%h z=%b o=%b l=%b",
                                     want.quo, want.zdiv, want.ovf, want.last,
                                     got.quo, got.zdiv, got.ovf, got.last);
                    end
                end
            end
            if (start && !busy)
                pending_quotients.push_back(predict_quotient(active_type, dividend,
                                                             divisor, last_in));
            if (cfg_we)
                active_type = cfg_data;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the divider regression. It generates requests and configuration
// writes only; all prediction and comparison lives in quotient_checker,
// which hands back its failure and outstanding counts for the verdict.
module testbench;
    import sidiv_pkg::*;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [DT_W-1:0]   cfg_data = '0;
    logic              start    = 1'b0;
    logic [DATA_W-1:0] dividend = '0;
    logic [DATA_W-1:0] divisor  = '0;
    logic              last_in  = 1'b0;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic              zero_divisor;
    logic              overflowed;
    logic              last_out;

    int fail_count;
    int outstanding;
    int checked_count;
    int zero_div_count;
    int overflow_count;

    // Bookkeeping for the summary and for the sender's idling.
    int unsigned     requests_sent = 0;
    int unsigned     type_writes   = 0;
    bit              no_gaps       = 1'b0;
    logic [DT_W-1:0] current_type  = DT_INT32;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    saturating_integer_divider uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .dividend     (dividend),
        .divisor      (divisor),
        .last_in      (last_in),
        .done         (done),
        .quotient     (quotient),
        .zero_divisor (zero_divisor),
        .overflowed   (overflowed),
        .last_out     (last_out)
    );

    quotient_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .dividend       (dividend),
        .divisor        (divisor),
        .last_in        (last_in),
        .done           (done),
        .quotient       (quotient),
        .zero_divisor   (zero_divisor),
        .overflowed     (overflowed),
        .last_out       (last_out),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .checked_count  (checked_count),
        .zero_div_count (zero_div_count),
        .overflow_count (overflow_count)
    );

    // Offers one request after a random gap and returns at the clock edge
    // that accepted it. The gap is skipped in burst stretches so that
    // back-to-back requests also fill the pipeline. Busy is sampled on the
    // falling edge, where it is stable, and start stays high into the next
    // request when that one comes without a gap.
    task automatic send_request(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                input logic last);
        int unsigned gap;
        bit          took;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        dividend <= a;
        divisor  <= b;
        last_in  <= last;
        do begin
            @(negedge clk);
            took = !busy;
            @(posedge clk);
        end while (!took);
        requests_sent++;
    endtask

    // Stops sending and waits until the checker holds no expected result,
    // which also means nothing is left in flight inside the divider.
    task automatic drain_pipeline();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // The data type is read at both ends of the pipeline, so it is only
    // changed once every request has come back out.
    task automatic set_data_type(input logic [DT_W-1:0] dt);
        drain_pipeline();
        cfg_we   <= 1'b1;
        cfg_data <= dt;
        @(posedge clk);
        cfg_we <= 1'b0;
        current_type = dt;
        type_writes++;
    endtask

    function automatic int unsigned width_of(input logic [DT_W-1:0] dt);
        return 8 << dt[2:1];
    endfunction

    // Draws one operand for the current width. The bits above the width are
    // always random, since the divider must ignore them; the low bits are
    // biased toward zero, minus one, small values and the type limits,
    // where the saturation and sign handling live.
    function automatic logic [DATA_W-1:0] pick_operand(input int unsigned w,
                                                       input bit          as_divisor);
        logic [DATA_W-1:0] keep, raw, v;
        int unsigned       sel;
        keep = (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
        raw  = {$urandom, $urandom};
        sel  = $urandom_range(0, 99);
        if (as_divisor) begin
            if (sel < 8)
                v = '0;
            else if (sel < 16)
                v = keep;
            else if (sel < 36)
                v = 64'($urandom_range(1, 9));
            else if (sel < 46)
                v = 64'd0 - 64'($urandom_range(1, 9));
            else if (sel < 52)
                v = (keep >> 1) + 64'd1;
            else if (sel < 75)
                v = raw >> $urandom_range(0, w - 1);
            else
                v = raw;
        end
        else begin
            if (sel < 8)
                v = (keep >> 1) + 64'd1;
            else if (sel < 14)
                v = keep >> 1;
            else if (sel < 20)
                v = '0;
            else if (sel < 26)
                v = keep;
            else if (sel < 35)
                v = 64'($urandom_range(1, 20));
            else if (sel < 65)
                v = raw;
            else
                v = raw >> $urandom_range(0, 63);
        end
        return (raw & ~keep) | (v & keep);
    endfunction

    initial
    begin
        logic [DT_W-1:0]   phase_types[12];
        logic [DATA_W-1:0] keep, a, b;
        int unsigned       w;
        phase_types = '{3'd2, 3'd3, 3'd5, 3'd0, 3'd7, 3'd1, 3'd6, 3'd4,
                        3'd0, 3'd7, 3'd0, 3'd7};
        // Each of the last four phases draws its type at random half the time.
        for (int i = 8; i < 12; i++)
            if ($urandom_range(0, 1))
                phase_types[i] = DT_W'($urandom_range(0, 7));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first at the int32 type that reset leaves behind:
        // plain signed division with operands of either sign, the minimum
        // over minus one, division by zero with positive, zero and negative
        // dividends, and garbage in the upper operand bits.
        send_request(64'd7, 64'd2, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 1'b0);
        send_request(64'd7, 64'h0000_0000_FFFF_FFFE, 1'b0);
        send_request(64'h0000_0000_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_request(64'd5, 64'd0, 1'b0);
        send_request(64'd0, 64'd0, 1'b0);
        send_request(64'h0000_0000_FFFF_FFFB, 64'd0, 1'b0);
        send_request(64'hDEAD_BEEF_0000_0064, 64'h1234_5678_0000_000A, 1'b0);
        send_request(64'd9, 64'hFFFF_FFFF_0000_0000, 1'b1);

        // The 64 bit signed limits.
        set_data_type(3'd6);
        send_request(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_request(64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b0);
        send_request(64'h8000_0000_0000_0000, 64'd0, 1'b0);
        send_request(64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 1'b0);
        send_request(64'h8000_0000_0000_0000, 64'd3, 1'b1);

        // The 8 bit signed limits, with the upper bits set around them.
        set_data_type(3'd0);
        send_request(64'hAAAA_AAAA_AAAA_AA80, 64'h5555_5555_5555_55FF, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FF7F, 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
        send_request(64'h0000_0000_0000_0080, 64'd0, 1'b0);
        send_request(64'h0000_0000_0000_0081, 64'h0000_0000_0000_007F, 1'b1);

        // Unsigned 64 bit: the full range, zero over zero and the all-ones
        // pattern that would be minus one as a signed value.
        set_data_type(3'd7);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0);
        send_request(64'd0, 64'd0, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        // Unsigned 8 bit.
        set_data_type(3'd1);
        send_request(64'h0000_0000_0000_00FF, 64'd0, 1'b0);
        send_request(64'h0000_0000_0000_0000, 64'd0, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF02, 1'b1);

        // Random part: one phase per type setting; every setting is reached,
        // and later phases revisit both extremes unless drawn at random. The
        // sender alternates random gaps and gap-free bursts within a phase.
        for (int phase = 0; phase < 12; phase++) begin
            set_data_type(phase_types[phase]);
            w    = width_of(current_type);
            keep = (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
            for (int n = 0; n < 155; n++) begin
                if (n % 40 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                // Hold off once in the first phase, and now and then later,
                // until every outstanding result has come back.
                if ((phase == 0 && n == 60) || $urandom_range(0, 299) == 0)
                    drain_pipeline();
                a = pick_operand(w, 1'b0);
                b = pick_operand(w, 1'b1);
                // Force the minimum over minus one now and then, since the
                // independent draws rarely line it up.
                if ($urandom_range(0, 19) == 0) begin
                    a = ({$urandom, $urandom} & ~keep) | ((keep >> 1) + 64'd1);
                    b = {$urandom, $urandom} | keep;
                end
                send_request(a, b, $urandom_range(0, 7) == 0);
            end
        end

        // Let every result come out, then give the pipeline its full
        // latency again so that any stray result would still be caught.
        drain_pipeline();
        repeat (LATENCY + 8) @(posedge clk);

        $display("Covered %0d requests over %0d data type writes across all eight types.",
                 requests_sent, type_writes);
        $display("Checked %0d results, %0d with a zero divisor and %0d with an overflow.",
                 checked_count, zero_div_count, overflow_count);
        if (fail_count == 0 && outstanding == 0)
            $display("saturating_integer_divider regression: pass");
        else
            $display("saturating_integer_divider regression: fail");
        $finish;
    end

    // Watchdog: the slowest legal run needs well under a tenth of this.
    initial
    begin
        #1000000;
        $display("saturating_integer_divider regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sidiv_pkg.sv
rtl/core/sidiv_prep.sv
rtl/core/sidiv_cell.sv
rtl/core/sidiv_post.sv
rtl/core/saturating_integer_divider.sv
rtl/core/sidiv_checker.sv
tb/quotient_checker.sv
tb/testbench.sv
